// File: src/bole_pkg.sv
// Shared types and constants of the bounded ordered list engine.
package bole_pkg;

    localparam int MAX_RESULTS = 16;
    localparam int NRW         = $clog2(MAX_RESULTS);

    typedef enum logic [2:0] {
        A_PUSH_FRONT = 3'd0,
        A_PUSH_BACK  = 3'd1,
        A_POP_FRONT  = 3'd2,
        A_POP_BACK   = 3'd3,
        A_INSERT_AT  = 3'd4,
        A_DELETE_AT  = 3'd5,
        A_FIND       = 3'd6
    } t_action;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_FULL     = 3'd2,
        ST_RANGE    = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        C_HOLD,
        C_LOAD,
        C_FROM_LEFT,
        C_FROM_RIGHT
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     capture;
        logic     clear;
    } t_cell_ctrl;

    typedef enum logic {
        S_IDLE,
        S_FIND
    } t_state;

endpackage

// File: src/bole_cell.sv
// One list cell: holds a value, shifts with its neighbours and flags a search match.
module bole_cell
    import bole_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cell_ctrl             i_ctrl,
    input  logic [VALUE_WIDTH-1:0] i_load_value,
    input  logic [VALUE_WIDTH-1:0] i_left,
    input  logic [VALUE_WIDTH-1:0] i_right,
    input  logic                   i_in_use,
    input  logic [VALUE_WIDTH-1:0] i_search,
    output logic [VALUE_WIDTH-1:0] o_value,
    output logic                   o_flag
);

    logic [VALUE_WIDTH-1:0] r_value;
    logic [VALUE_WIDTH-1:0] n_value;
    logic                   r_flag;
    logic                   n_flag;

    always_comb begin
        case (i_ctrl.op)
            C_LOAD:       n_value = i_load_value;
            C_FROM_LEFT:  n_value = i_left;
            C_FROM_RIGHT: n_value = i_right;
            default:      n_value = r_value;
        endcase
    end

    always_comb begin
        n_flag = r_flag;
        if (i_ctrl.capture) begin
            n_flag = i_in_use && (r_value == i_search);
        end else if (i_ctrl.clear) begin
            n_flag = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag <= 1'b0;
        end else begin
            r_flag <= n_flag;
        end
    end

    assign o_value = r_value;
    assign o_flag  = r_flag;

endmodule

// File: src/bounded_ordered_list_engine_top.sv
// Top level of the bounded ordered list engine: control, count and the row of cells.
//
//  channel   direction  handshake              words
//  request   in         i_start, o_busy        i_action, i_index, i_item_value
//  result    out        o_strobe (one cycle)   o_status, o_position, o_count, o_last
//
// Push, pop, insert and delete shift the cell row in the cycle of acceptance; the
// result word follows in the next cycle and o_busy stays low, so one request a cycle.
// A find compares every cell at acceptance, then gives one result word a cycle per
// match (at most MAX_RESULTS), or one not-found word; o_busy is high meanwhile.
// Reset clears the count, match flags and control; cell values are undefined until
// written. The receiver cannot stall: each result word shows for exactly one cycle.
module bounded_ordered_list_engine_top
    import bole_pkg::*;
#(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [2:0]         i_action,
    input  logic [4:0]         i_index,
    input  logic signed [31:0] i_item_value,
    output logic               o_strobe,
    output logic [2:0]         o_status,
    output logic [4:0]         o_position,
    output logic [4:0]         o_count,
    output logic               o_last
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CW > 5) ? CW : 5;
    localparam int PW = $clog2(CAPACITY);

    t_state                 r_state;
    t_state                 n_state;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    logic [NRW-1:0]         r_nres;
    logic [NRW-1:0]         n_nres;

    logic                   r_strobe;
    logic                   n_strobe;
    t_status                r_status;
    t_status                n_status;
    logic [4:0]             r_position;
    logic [4:0]             n_position;
    logic [4:0]             r_out_count;
    logic [4:0]             n_out_count;
    logic                   r_last;
    logic                   n_last;

    logic                   accept;
    t_action                action;
    logic [VALUE_WIDTH-1:0] value;
    logic [IW-1:0]          idx_ext;
    logic [IW-1:0]          cnt_ext;
    logic [IW-1:0]          at;
    logic                   do_ins;
    logic                   do_del;
    logic                   do_capture;
    logic                   full;
    logic                   empty;

    logic [CAPACITY-1:0]    flags;
    logic [CAPACITY-1:0]    sel;
    logic [CAPACITY-1:0]    remaining;
    logic [PW-1:0]          sel_idx;
    logic [PW:0]            sel_pos;
    logic                   find_last;

    logic [VALUE_WIDTH-1:0] cell_value [CAPACITY];
    t_cell_ctrl             cell_ctrl  [CAPACITY];
    logic [CAPACITY-1:0]    in_use;

    assign o_busy  = (r_state == S_FIND);
    assign accept  = i_start && !o_busy;
    assign action  = t_action'(i_action);
    assign value   = VALUE_WIDTH'(i_item_value);
    assign idx_ext = IW'(i_index);
    assign cnt_ext = IW'(r_count);
    assign full    = (r_count == CW'(CAPACITY));
    assign empty   = (r_count == '0);

    // lowest pending match goes out first
    assign sel       = flags & (~flags + CAPACITY'(1));
    assign remaining = flags & ~sel;
    assign sel_pos   = {1'b0, sel_idx} + (PW + 1)'(1);
    assign find_last = (remaining == '0) || (r_nres == NRW'(MAX_RESULTS - 1));

    always_comb begin
        sel_idx = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (sel[i]) begin
                sel_idx = sel_idx | PW'(i);
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && action == A_FIND && !empty) begin
                    n_state = S_FIND;
                end
            end
            S_FIND: begin
                if (flags == '0 || find_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and datapath control
    always_comb begin
        at          = '0;
        do_ins      = 1'b0;
        do_del      = 1'b0;
        do_capture  = 1'b0;
        n_count     = r_count;
        n_nres      = r_nres;
        n_strobe    = 1'b0;
        n_status    = ST_OK;
        n_position  = '0;
        n_last      = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_strobe = 1'b1;
                    n_nres   = '0;
                    case (action)
                        A_PUSH_FRONT: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                do_ins = 1'b1;
                            end
                        end
                        A_PUSH_BACK: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                do_ins = 1'b1;
                                at     = cnt_ext;
                            end
                        end
                        A_POP_FRONT: begin
                            if (empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                do_del = 1'b1;
                            end
                        end
                        A_POP_BACK: begin
                            if (empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                do_del = 1'b1;
                                at     = cnt_ext - IW'(1);
                            end
                        end
                        A_INSERT_AT: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else if (idx_ext > cnt_ext) begin
                                n_status = ST_RANGE;
                            end else begin
                                do_ins = 1'b1;
                                at     = idx_ext;
                            end
                        end
                        A_DELETE_AT: begin
                            if (empty) begin
                                n_status = ST_EMPTY;
                            end else if (idx_ext >= cnt_ext) begin
                                n_status = ST_RANGE;
                            end else begin
                                do_del = 1'b1;
                                at     = idx_ext;
                            end
                        end
                        A_FIND: begin
                            if (empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                // hold the result word until the flags are in
                                n_strobe   = 1'b0;
                                do_capture = 1'b1;
                            end
                        end
                        default: n_status = ST_OK;
                    endcase
                    if (do_ins) begin
                        n_count = r_count + CW'(1);
                    end else if (do_del) begin
                        n_count = r_count - CW'(1);
                    end
                end
            end
            S_FIND: begin
                n_strobe = 1'b1;
                if (flags == '0) begin
                    n_status = ST_NOTFOUND;
                end else begin
                    n_position = 5'(sel_pos);
                    n_last     = find_last;
                    n_nres     = r_nres + NRW'(1);
                end
            end
            default: n_strobe = 1'b0;
        endcase
        n_out_count = 5'(n_count);
    end

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            in_use[i]            = (CW'(i) < r_count);
            cell_ctrl[i].op      = C_HOLD;
            cell_ctrl[i].capture = do_capture;
            cell_ctrl[i].clear   = (r_state == S_FIND) && sel[i];
            if (do_ins) begin
                if (IW'(i) > at) begin
                    cell_ctrl[i].op = C_FROM_LEFT;
                end else if (IW'(i) == at) begin
                    cell_ctrl[i].op = C_LOAD;
                end
            end else if (do_del && IW'(i) >= at) begin
                cell_ctrl[i].op = C_FROM_RIGHT;
            end
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VALUE_WIDTH-1:0] left;
        logic [VALUE_WIDTH-1:0] right;

        if (g == 0) begin : g_first
            assign left = value;
        end else begin : g_inner_left
            assign left = cell_value[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right = '0;
        end else begin : g_inner_right
            assign right = cell_value[g+1];
        end

        bole_cell #(
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (cell_ctrl[g]),
            .i_load_value (value),
            .i_left       (left),
            .i_right      (right),
            .i_in_use     (in_use[g]),
            .i_search     (value),
            .o_value      (cell_value[g]),
            .o_flag       (flags[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_nres   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_nres   <= n_nres;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status    <= n_status;
        r_position  <= n_position;
        r_out_count <= n_out_count;
        r_last      <= n_last;
    end

    assign o_strobe   = r_strobe;
    assign o_status   = r_status;
    assign o_position = r_position;
    assign o_count    = r_out_count;
    assign o_last     = r_last;

endmodule
